>>> hdl/voxel_greedy_mesher_core_assert.svh
// Assertion macros used by the mesher core.
`ifndef VOXEL_GREEDY_MESHER_CORE_ASSERT_SVH
`define VOXEL_GREEDY_MESHER_CORE_ASSERT_SVH

// Condition must hold at every rising clock edge outside reset.
`define VGM_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define VGM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> hdl/vgm_pkg.sv
package vgm_pkg;

   // Configuration register indexes.
   localparam logic [1:0] REG_OFFSET_X = 2'd0;
   localparam logic [1:0] REG_OFFSET_Y = 2'd1;
   localparam logic [1:0] REG_OFFSET_Z = 2'd2;

   localparam int OFFSET_W = 24;
   localparam int CORNER_W = 25;
   localparam int EXTENT_W = 6;

   // Input kinds carried in req_tuser.
   localparam logic FUNC_WRITE_ROW = 1'b0;
   localparam logic FUNC_NEXT_QUAD = 1'b1;

   // Normal axes.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [2:0] {
      MASK_NONE,
      MASK_ROW,
      MASK_COL,
      MASK_CELL,
      MASK_CLEAR
   } mask_op_type;

   // Write command into the face mask lanes.
   typedef struct packed {
      mask_op_type op;
      logic        sel_cmp;   // 0 writes the rear plane, 1 the front plane
      logic [1:0]  cell_bits; // bit 0 rear, bit 1 front, for single-cell writes
   } mask_cmd_type;

endpackage

>>> hdl/vgm_occ_mem.sv
module vgm_occ_mem #(
   parameter int N   = 32,
   parameter int LOG = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [2*LOG-1:0] wr_addr,
   input  logic [N-1:0]     wr_data,
   input  logic             rd_en,
   input  logic [2*LOG-1:0] rd_addr,
   output logic [N-1:0]     rd_data
);

   logic [N-1:0] mem_ff [N*N];
   logic [N-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/vgm_mask_lanes.sv
module vgm_mask_lanes #(
   parameter int N   = 32,
   parameter int LOG = 5
) (
   input  logic                  clock,
   input  vgm_pkg::mask_cmd_type cmd,
   input  logic [LOG-1:0]        wr_row,
   input  logic [LOG-1:0]        wr_col,
   input  logic [N-1:0]          wr_vec,
   input  logic [LOG-1:0]        rd_row,
   output logic [N-1:0]          rd_cur,
   output logic [N-1:0]          rd_cmp
);

   // One entry per mask row: rear and front occupancy of the plane pair.
   logic [N-1:0] cur_ff [N];
   logic [N-1:0] cmp_ff [N];

   always_ff @(posedge clock) begin
      case (cmd.op)
         vgm_pkg::MASK_ROW: begin
            if (cmd.sel_cmp) cmp_ff[wr_row] <= wr_vec;
            else cur_ff[wr_row] <= wr_vec;
         end
         vgm_pkg::MASK_COL: begin
            for (int r = 0; r < N; r++) begin
               if (cmd.sel_cmp) cmp_ff[r][wr_col] <= wr_vec[r];
               else cur_ff[r][wr_col] <= wr_vec[r];
            end
         end
         vgm_pkg::MASK_CELL: begin
            cur_ff[wr_row][wr_col] <= cmd.cell_bits[0];
            cmp_ff[wr_row][wr_col] <= cmd.cell_bits[1];
         end
         vgm_pkg::MASK_CLEAR: begin
            cur_ff[wr_row] <= cur_ff[wr_row] & ~wr_vec;
            cmp_ff[wr_row] <= cmp_ff[wr_row] & ~wr_vec;
         end
         default: begin
         end
      endcase
   end

   assign rd_cur = cur_ff[rd_row];
   assign rd_cmp = cmp_ff[rd_row];

endmodule

>>> hdl/vgm_run_find.sv
module vgm_run_find #(
   parameter int N   = 32,
   parameter int LOG = 5
) (
   input  logic [N-1:0]   cur,
   input  logic [N-1:0]   cmp,
   input  logic [LOG-1:0] start,
   output logic           found,
   output logic [LOG-1:0] first,
   output logic           negative,
   output logic [LOG:0]   width
);

   logic [N-1:0] face_vec;
   logic [N-1:0] match_vec;
   logic [N-1:0] stop_vec;
   logic [LOG:0] run_end;

   // Merge the lanes: first face cell at or after start, then the end of its run.
   always_comb begin
      for (int k = 0; k < N; k++) begin
         face_vec[k] = (cur[k] ^ cmp[k]) && (k >= int'(start));
      end
      found = |face_vec;
      first = '0;
      for (int k = N - 1; k >= 0; k--) begin
         if (face_vec[k]) first = LOG'(k);
      end
      negative = ~cur[first];
      match_vec = negative ? (~cur & cmp) : (cur & ~cmp);
      for (int k = 0; k < N; k++) begin
         stop_vec[k] = !match_vec[k] && (k >= int'(first));
      end
      run_end = (LOG + 1)'(N);
      for (int k = N - 1; k >= 0; k--) begin
         if (stop_vec[k]) run_end = (LOG + 1)'(k);
      end
      width = run_end - (LOG + 1)'(first);
   end

endmodule

>>> hdl/voxel_greedy_mesher_core.sv
// Greedy face mesher for a CHUNK_SIZE^3 voxel chunk. A row write (req_tuser 0) stores one X-row
// and rewinds the scan. A quad request (req_tuser 1) returns the next merged face quad, or done
// once all three axes are finished. Each time the scan reaches a new face plane, the mask is
// built from the occupancy memory through its single read port: one row read per mask cell for
// X-normal planes, two per mask row (Z) or mask column (Y) for the others. Scanning then searches
// the mask row by row and moves on to the next plane at the end, and each quad found is grown by
// row compares and then cleared row by row. Results sit in an output register, so row writes
// keep flowing while a result waits to be taken.
`include "voxel_greedy_mesher_core_assert.svh"

module voxel_greedy_mesher_core #(
   parameter int CHUNK_SIZE = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // row_y[4:0], row_z[9:5], row_bits[41:10], zero fill
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // face_axis[1:0], face_negative[2], corner_x[27:3],
                                    // corner_y[52:28], corner_z[77:53], quad_width[83:78],
                                    // quad_height[89:84], zero fill
   output logic        rsp_tuser,   // done_res
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [23:0] csr_wdata
);

   localparam int LOG = $clog2(CHUNK_SIZE);
   localparam int PW  = $clog2(CHUNK_SIZE + 1);
   localparam int CW  = 2 * LOG;
   localparam logic [CW-1:0] LAST_CELL = CW'(CHUNK_SIZE * CHUNK_SIZE - 1);
   localparam logic [CW-1:0] LAST_PAIR = CW'(2 * CHUNK_SIZE - 1);
   localparam logic [LOG:0]  N_ROWS    = (LOG + 1)'(CHUNK_SIZE);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD,
      ST_FLUSH,
      ST_SCAN,
      ST_GROW,
      ST_CLEAR,
      ST_RESULT
   } state_type;

   state_type state_ff;

   logic [23:0] off_x_ff, off_y_ff, off_z_ff;
   logic [1:0]  axis_ff;
   logic [PW-1:0] pl_ff;          // plane + 1
   logic [LOG:0]  j_ff;
   logic [LOG-1:0] i_ff;
   logic          built_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;

   logic          pend_ff;
   logic [CW-1:0] pend_cnt_ff;
   logic          pend_ok0_ff, pend_ok1_ff;
   logic [LOG-1:0] pend_b0_ff, pend_b1_ff;

   logic [LOG-1:0] f_ff;
   logic [LOG:0]   w_ff, h_ff, l_ff;
   logic [LOG:0]   qj_ff;
   logic           neg_ff;
   logic           res_done_ff;

   logic           rsp_tvalid_ff;
   logic           rsp_done_ff;
   logic [1:0]     rsp_axis_ff;
   logic           rsp_neg_ff;
   logic [24:0]    rsp_cx_ff, rsp_cy_ff, rsp_cz_ff;
   logic [5:0]     rsp_w_ff, rsp_h_ff;

   // Input fields.
   logic [4:0]  row_y, row_z;
   logic [31:0] row_bits;
   logic        req_xfer;
   logic        row_in_range;

   assign row_y    = req_tdata[4:0];
   assign row_z    = req_tdata[9:5];
   assign row_bits = req_tdata[41:10];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign row_in_range = (int'(row_y) < CHUNK_SIZE) && (int'(row_z) < CHUNK_SIZE);

   // Build read addressing.
   logic          rd_sel;
   logic [LOG-1:0] rd_idx;
   logic [PW-1:0] rd_plane;
   logic          rd_ok;
   logic [CW-1:0] rd_addr;
   logic [CW-1:0] build_last;
   logic [CHUNK_SIZE-1:0] occ_rd_data;

   always_comb begin
      rd_sel   = cnt_ff[0];
      rd_idx   = cnt_ff[LOG:1];
      rd_plane = rd_sel ? pl_ff : pl_ff - PW'(1);
      rd_ok    = rd_sel ? (pl_ff < PW'(CHUNK_SIZE)) : (pl_ff != '0);
      case (axis_ff)
         vgm_pkg::AXIS_Z: rd_addr = {rd_plane[LOG-1:0], rd_idx};
         vgm_pkg::AXIS_Y: rd_addr = {rd_idx, rd_plane[LOG-1:0]};
         default:         rd_addr = cnt_ff;
      endcase
      build_last = (axis_ff == vgm_pkg::AXIS_X) ? LAST_CELL : LAST_PAIR;
   end

   vgm_occ_mem #(.N(CHUNK_SIZE), .LOG(LOG)) u_occ (
      .clock   (clock),
      .wr_en   (req_xfer && req_tuser == vgm_pkg::FUNC_WRITE_ROW && row_in_range),
      .wr_addr ({LOG'(row_z), LOG'(row_y)}),
      .wr_data (CHUNK_SIZE'(row_bits)),
      .rd_en   (state_ff == ST_BUILD),
      .rd_addr (rd_addr),
      .rd_data (occ_rd_data)
   );

   // Mask writes and reads.
   vgm_pkg::mask_cmd_type mask_cmd;
   logic [LOG-1:0] mask_wr_row, mask_wr_col, mask_rd_row;
   logic [CHUNK_SIZE-1:0] mask_wr_vec;
   logic [CHUNK_SIZE-1:0] row_cur, row_cmp;
   logic [CHUNK_SIZE-1:0] win_vec;
   logic [CHUNK_SIZE-1:0] grow_match;
   logic [LOG:0] clear_row;

   always_comb begin
      win_vec = ({CHUNK_SIZE{1'b1}} >> (N_ROWS - w_ff)) << f_ff;
      clear_row = qj_ff + l_ff;
      mask_cmd.op        = vgm_pkg::MASK_NONE;
      mask_cmd.sel_cmp   = pend_cnt_ff[0];
      mask_cmd.cell_bits = {pend_ok1_ff & occ_rd_data[pend_b1_ff],
                            pend_ok0_ff & occ_rd_data[pend_b0_ff]};
      mask_wr_row = pend_cnt_ff[LOG:1];
      mask_wr_col = pend_cnt_ff[LOG:1];
      mask_wr_vec = pend_ok0_ff ? occ_rd_data : '0;
      if (pend_ff) begin
         case (axis_ff)
            vgm_pkg::AXIS_Z: mask_cmd.op = vgm_pkg::MASK_ROW;
            vgm_pkg::AXIS_Y: mask_cmd.op = vgm_pkg::MASK_COL;
            default: begin
               mask_cmd.op = vgm_pkg::MASK_CELL;
               mask_wr_row = pend_cnt_ff[CW-1:LOG];
               mask_wr_col = pend_cnt_ff[LOG-1:0];
            end
         endcase
      end else if (state_ff == ST_CLEAR) begin
         mask_cmd.op = vgm_pkg::MASK_CLEAR;
         mask_wr_row = clear_row[LOG-1:0];
         mask_wr_vec = win_vec;
      end
      if (state_ff == ST_GROW) mask_rd_row = LOG'(j_ff + h_ff);
      else mask_rd_row = j_ff[LOG-1:0];
      grow_match = neg_ff ? (~row_cur & row_cmp) : (row_cur & ~row_cmp);
   end

   vgm_mask_lanes #(.N(CHUNK_SIZE), .LOG(LOG)) u_mask (
      .clock  (clock),
      .cmd    (mask_cmd),
      .wr_row (mask_wr_row),
      .wr_col (mask_wr_col),
      .wr_vec (mask_wr_vec),
      .rd_row (mask_rd_row),
      .rd_cur (row_cur),
      .rd_cmp (row_cmp)
   );

   logic           fnd;
   logic [LOG-1:0] fnd_first;
   logic           fnd_neg;
   logic [LOG:0]   fnd_width;

   vgm_run_find #(.N(CHUNK_SIZE), .LOG(LOG)) u_find (
      .cur      (row_cur),
      .cmp      (row_cmp),
      .start    (i_ff),
      .found    (fnd),
      .first    (fnd_first),
      .negative (fnd_neg),
      .width    (fnd_width)
   );

   logic [LOG+1:0] grow_next;
   logic [LOG:0]   next_cell;
   logic [24:0]    base_x, base_y, base_z;

   always_comb begin
      grow_next = (LOG + 2)'(j_ff) + (LOG + 2)'(h_ff);
      next_cell = (LOG + 1)'(f_ff) + w_ff;
      case (axis_ff)
         vgm_pkg::AXIS_X: begin
            base_x = 25'(pl_ff); base_y = 25'(f_ff); base_z = 25'(qj_ff);
         end
         vgm_pkg::AXIS_Y: begin
            base_y = 25'(pl_ff); base_z = 25'(f_ff); base_x = 25'(qj_ff);
         end
         default: begin
            base_z = 25'(pl_ff); base_x = 25'(f_ff); base_y = 25'(qj_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         off_x_ff      <= '0;
         off_y_ff      <= '0;
         off_z_ff      <= '0;
         axis_ff       <= vgm_pkg::AXIS_X;
         pl_ff         <= '0;
         j_ff          <= '0;
         i_ff          <= '0;
         built_ff      <= 1'b0;
         done_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               vgm_pkg::REG_OFFSET_X: off_x_ff <= csr_wdata;
               vgm_pkg::REG_OFFSET_Y: off_y_ff <= csr_wdata;
               vgm_pkg::REG_OFFSET_Z: off_z_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_tready && state_ff != ST_RESULT) rsp_tvalid_ff <= 1'b0;
         pend_ff <= (state_ff == ST_BUILD);

         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  if (req_tuser == vgm_pkg::FUNC_WRITE_ROW) begin
                     axis_ff  <= vgm_pkg::AXIS_X;
                     pl_ff    <= '0;
                     j_ff     <= '0;
                     i_ff     <= '0;
                     built_ff <= 1'b0;
                     done_ff  <= 1'b0;
                  end else if (done_ff) begin
                     res_done_ff <= 1'b1;
                     state_ff    <= ST_RESULT;
                  end else if (!built_ff) begin
                     cnt_ff   <= '0;
                     state_ff <= ST_BUILD;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_BUILD: begin
               pend_cnt_ff <= cnt_ff;
               pend_ok0_ff <= (axis_ff == vgm_pkg::AXIS_X) ? (pl_ff != '0) : rd_ok;
               pend_ok1_ff <= pl_ff < PW'(CHUNK_SIZE);
               pend_b0_ff  <= LOG'(pl_ff - PW'(1));
               pend_b1_ff  <= LOG'(pl_ff);
               cnt_ff      <= cnt_ff + CW'(1);
               if (cnt_ff == build_last) state_ff <= ST_FLUSH;
            end
            ST_FLUSH: begin
               built_ff <= 1'b1;
               j_ff     <= '0;
               i_ff     <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (j_ff == N_ROWS) begin
                  built_ff <= 1'b0;
                  cnt_ff   <= '0;
                  if (pl_ff == PW'(CHUNK_SIZE)) begin
                     pl_ff <= '0;
                     if (axis_ff == vgm_pkg::AXIS_Z) begin
                        done_ff     <= 1'b1;
                        res_done_ff <= 1'b1;
                        state_ff    <= ST_RESULT;
                     end else begin
                        axis_ff  <= axis_ff + 2'd1;
                        state_ff <= ST_BUILD;
                     end
                  end else begin
                     pl_ff    <= pl_ff + PW'(1);
                     state_ff <= ST_BUILD;
                  end
               end else if (fnd) begin
                  f_ff     <= fnd_first;
                  w_ff     <= fnd_width;
                  neg_ff   <= fnd_neg;
                  qj_ff    <= j_ff;
                  h_ff     <= (LOG + 1)'(1);
                  state_ff <= ST_GROW;
               end else begin
                  j_ff <= j_ff + (LOG + 1)'(1);
                  i_ff <= '0;
               end
            end
            ST_GROW: begin
               if (grow_next < (LOG + 2)'(CHUNK_SIZE) && (grow_match & win_vec) == win_vec) begin
                  h_ff <= h_ff + (LOG + 1)'(1);
               end else begin
                  l_ff     <= '0;
                  state_ff <= ST_CLEAR;
               end
            end
            ST_CLEAR: begin
               l_ff <= l_ff + (LOG + 1)'(1);
               if (l_ff + (LOG + 1)'(1) == h_ff) begin
                  if (next_cell == N_ROWS) begin
                     j_ff <= j_ff + (LOG + 1)'(1);
                     i_ff <= '0;
                  end else begin
                     i_ff <= next_cell[LOG-1:0];
                  end
                  res_done_ff <= 1'b0;
                  state_ff    <= ST_RESULT;
               end
            end
            ST_RESULT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_done_ff   <= res_done_ff;
                  state_ff      <= ST_IDLE;
                  if (res_done_ff) begin
                     rsp_axis_ff <= '0;
                     rsp_neg_ff  <= 1'b0;
                     rsp_cx_ff   <= '0;
                     rsp_cy_ff   <= '0;
                     rsp_cz_ff   <= '0;
                     rsp_w_ff    <= '0;
                     rsp_h_ff    <= '0;
                  end else begin
                     rsp_axis_ff <= axis_ff;
                     rsp_neg_ff  <= neg_ff;
                     rsp_cx_ff   <= {off_x_ff[23], off_x_ff} + base_x;
                     rsp_cy_ff   <= {off_y_ff[23], off_y_ff} + base_y;
                     rsp_cz_ff   <= {off_z_ff[23], off_z_ff} + base_z;
                     rsp_w_ff    <= 6'(w_ff);
                     rsp_h_ff    <= 6'(h_ff);
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_done_ff;
   assign rsp_tdata  = {6'd0, rsp_h_ff, rsp_w_ff, rsp_cz_ff, rsp_cy_ff, rsp_cx_ff,
                        rsp_neg_ff, rsp_axis_ff};

   `VGM_ASSERT_IMPLIES(a_done_fields_zero, rsp_tvalid_ff && rsp_done_ff, rsp_tdata == '0, "done result carries nonzero fields")
   `VGM_ASSERT_IMPLIES(a_quad_nonempty, rsp_tvalid_ff && !rsp_done_ff, rsp_w_ff != '0 && rsp_h_ff != '0, "quad with zero extent")
   `VGM_ASSERT_IMPLIES(a_mask_fill_from_build, pend_ff, $past(state_ff) == ST_BUILD, "mask fill outside build pass")
   `VGM_ASSERT_IMPLIES(a_quad_axis_valid, rsp_tvalid_ff, rsp_axis_ff != 2'd3, "quad axis out of range")

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int CS = 32;
   localparam int CELLS = CS * CS;
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 200000;
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic        func;
      logic [4:0]  y;
      logic [4:0]  z;
      logic [31:0] bits;
   } row_item_type;

   typedef struct {
      logic        done;
      logic [1:0]  axis;
      logic        neg;
      logic [24:0] corner[3];
      logic [5:0]  w;
      logic [5:0]  h;
   } quad_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [23:0] csr_wdata = '0;

   voxel_greedy_mesher_core #(.CHUNK_SIZE(CS)) dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mesher shadow state.
   logic [31:0] occ_rows[CELLS];
   logic [1:0]  fmask[CELLS];
   logic [23:0] offs[3];
   int          scan_axis, scan_plane, scan_cell;
   bit          mask_ready, scan_finished, saw_done;

   row_item_type item_q[$];
   row_item_type cur_item;
   quad_type     quad_q[$];
   int          errors = 0;
   int          gap = 0, stall = 0, hold_cnt = 0, idle_cycles = 0;
   bit          no_idle = 0, hold_req = 0;

   function automatic bit voxel_at(int c[3]);
      for (int k = 0; k < 3; k++)
         if (c[k] < 0 || c[k] >= CS) return 0;
      return occ_rows[c[2] * CS + c[1]][c[0]];
   endfunction

   function automatic void build_face_mask();
      int a1, a2;
      int c[3];
      bit cur, nxt;
      a1 = (scan_axis + 1) % 3;
      a2 = (scan_axis + 2) % 3;
      for (int j = 0; j < CS; j++) begin
         for (int i = 0; i < CS; i++) begin
            c[a1] = i;
            c[a2] = j;
            c[scan_axis] = scan_plane;
            cur = voxel_at(c);
            c[scan_axis] = scan_plane + 1;
            nxt = voxel_at(c);
            fmask[j * CS + i] = (cur == nxt) ? 2'd0 : (cur ? 2'd1 : 2'd2);
         end
      end
   endfunction

   function automatic quad_type grow_quad();
      quad_type q;
      int n, i, j, w, h, a1, a2, v;
      int c[3];
      logic [1:0] m;
      bit stop;
      n = scan_cell;
      i = n % CS;
      j = n / CS;
      m = fmask[n];
      a1 = (scan_axis + 1) % 3;
      a2 = (scan_axis + 2) % 3;
      stop = 0;
      for (w = 1; i + w < CS && fmask[n + w] == m; w++) begin
      end
      for (h = 1; j + h < CS; h++) begin
         for (int k = 0; k < w; k++)
            if (fmask[n + k + h * CS] != m) stop = 1;
         if (stop) break;
      end
      for (int l = 0; l < h; l++)
         for (int k = 0; k < w; k++)
            fmask[n + k + l * CS] = 2'd0;
      scan_cell = n + w;
      c[scan_axis] = scan_plane + 1;
      c[a1] = i;
      c[a2] = j;
      q.done = 1'b0;
      q.axis = scan_axis[1:0];
      q.neg = (m == 2'd2);
      for (int k = 0; k < 3; k++) begin
         v = c[k] + int'($signed(offs[k]));
         q.corner[k] = v[24:0];
      end
      q.w = w[5:0];
      q.h = h[5:0];
      return q;
   endfunction

   function automatic quad_type next_quad();
      quad_type q;
      forever begin
         if (scan_finished) begin
            q.done = 1'b1;
            q.axis = '0;
            q.neg = 1'b0;
            for (int k = 0; k < 3; k++) q.corner[k] = '0;
            q.w = '0;
            q.h = '0;
            saw_done = 1;
            return q;
         end
         if (!mask_ready) begin
            build_face_mask();
            scan_cell = 0;
            mask_ready = 1;
         end
         while (scan_cell < CELLS) begin
            if (fmask[scan_cell] != 2'd0) return grow_quad();
            scan_cell++;
         end
         mask_ready = 0;
         scan_plane++;
         if (scan_plane >= CS) begin
            scan_plane = -1;
            scan_axis++;
            if (scan_axis >= 3) scan_finished = 1;
         end
      end
   endfunction

   function automatic void rewind_scan();
      scan_axis = 0;
      scan_plane = -1;
      scan_cell = 0;
      mask_ready = 0;
      scan_finished = 0;
   endfunction

   function automatic void apply_item(row_item_type it);
      if (it.func == vgm_pkg::FUNC_WRITE_ROW) begin
         occ_rows[it.z * CS + it.y] = it.bits;
         rewind_scan();
      end else begin
         quad_q.push_back(next_quad());
      end
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] exp);
      $display("%0t: mismatch on %s: got %0h expected %0h", $realtime, what, got, exp);
      errors++;
   endtask

   // Driver: the current item stays on the bus until its transfer.
   always @(posedge clock) begin
      bit give;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_item(cur_item);
         if (!req_tvalid || req_tready) begin
            give = 0;
            if (gap > 0) begin
               gap--;
            end else if (item_q.size() > 0) begin
               if (!no_idle && $urandom_range(0, 15) == 0) begin
                  gap = $urandom_range(1, 16);
               end else begin
                  cur_item = item_q.pop_front();
                  give = 1;
               end
            end
            req_tvalid <= give;
            if (give) begin
               req_tdata <= {6'b0, cur_item.bits, cur_item.z, cur_item.y};
               req_tuser <= cur_item.func;
            end
         end
      end
   end

   // Monitor and receiver stalls.
   always @(posedge clock) begin
      quad_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (quad_q.size() == 0) begin
               report("unexpected result", {31'd0, rsp_tuser}, '0);
            end else begin
               e = quad_q.pop_front();
               if (rsp_tuser !== e.done) report("done_res", rsp_tuser, e.done);
               if (rsp_tdata[1:0] !== e.axis) report("face_axis", rsp_tdata[1:0], e.axis);
               if (rsp_tdata[2] !== e.neg) report("face_negative", rsp_tdata[2], e.neg);
               if (rsp_tdata[27:3] !== e.corner[0])
                  report("corner_x", rsp_tdata[27:3], e.corner[0]);
               if (rsp_tdata[52:28] !== e.corner[1])
                  report("corner_y", rsp_tdata[52:28], e.corner[1]);
               if (rsp_tdata[77:53] !== e.corner[2])
                  report("corner_z", rsp_tdata[77:53], e.corner[2]);
               if (rsp_tdata[83:78] !== e.w) report("quad_width", rsp_tdata[83:78], e.w);
               if (rsp_tdata[89:84] !== e.h) report("quad_height", rsp_tdata[89:84], e.h);
            end
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
         end else if (hold_req) begin
            hold_req = 0;
            hold_cnt = LONG_HOLD;
         end else if (stall > 0) begin
            stall--;
         end else if (!no_idle && $urandom_range(0, 15) == 0) begin
            stall = $urandom_range(1, 16);
         end
         rsp_tready <= (hold_cnt == 0 && stall == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

   task automatic push_row(int y, int z, logic [31:0] bits);
      row_item_type it;
      it.func = vgm_pkg::FUNC_WRITE_ROW;
      it.y = y[4:0];
      it.z = z[4:0];
      it.bits = bits;
      item_q.push_back(it);
   endtask

   task automatic push_request();
      row_item_type it;
      it.func = vgm_pkg::FUNC_NEXT_QUAD;
      it.y = 5'($urandom());
      it.z = 5'($urandom());
      it.bits = $urandom();
      item_q.push_back(it);
   endtask

   task automatic wait_drained();
      while (item_q.size() != 0 || req_tvalid || quad_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_offsets(logic [23:0] ox, logic [23:0] oy, logic [23:0] oz);
      logic [1:0]  addr[4];
      logic [23:0] val[4];
      wait_drained();
      repeat (40) @(posedge clock);
      addr = '{vgm_pkg::REG_OFFSET_X, vgm_pkg::REG_OFFSET_Y, vgm_pkg::REG_OFFSET_Z,
               REG_UNUSED};
      val = '{ox, oy, oz, 24'($urandom())};
      for (int k = 0; k < 4; k++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_addr <= addr[k];
         csr_wdata <= val[k];
         if (k < 3) offs[k] = val[k];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Requests go out in small batches until the shadow scan reaches the end.
   task automatic request_until_done(bit noisy);
      int sent;
      sent = 0;
      saw_done = 0;
      while (!saw_done && sent < 400) begin
         for (int k = 0; k < 8; k++) push_request();
         if (noisy && sent < 24 && $urandom_range(0, 2) == 0)
            push_row($urandom_range(0, 31), $urandom_range(0, 31), $urandom());
         sent += 8;
         while (item_q.size() > 1) @(negedge clock);
      end
      push_request();
   endtask

   function automatic logic [31:0] random_row();
      int lo, len;
      case ($urandom_range(0, 5))
         0, 1: return '0;
         2: return $urandom() & $urandom() & $urandom() & $urandom();
         3: return '1;
         default: begin
            lo = $urandom_range(0, 31);
            len = $urandom_range(1, 32 - lo);
            return 32'(((33'd1 << len) - 33'd1) << lo);
         end
      endcase
   endfunction

   initial begin
      for (int k = 0; k < CELLS; k++) begin
         occ_rows[k] = '0;
         fmask[k] = '0;
      end
      for (int k = 0; k < 3; k++) offs[k] = '0;
      rewind_scan();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Every row is written before the first request reads the volume.
      for (int z = 0; z < CS; z++)
         for (int y = 0; y < CS; y++)
            push_row(y, z, '0);
      // Empty volume: the first request already returns done, and requests past the end stay done.
      push_request();
      push_request();
      push_row(31, 31, '1);
      push_row(0, 0, 32'h0000_0001);
      push_row(5, 7, 32'h8000_0001);
      push_row(6, 7, 32'h8000_0001);
      request_until_done(0);

      for (int scene = 0; scene < 9; scene++) begin
         case (scene)
            1: write_offsets(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
            2: write_offsets(24'h800000, 24'h7FFFFF, 24'h800000);
            5: write_offsets(24'hFFFFFF, 24'h000001, 24'h000000);
            default: if (scene > 2)
               write_offsets($urandom(), $urandom(), $urandom());
         endcase
         if (scene == 8) no_idle = 1;
         for (int k = $urandom_range(6, 14); k > 0; k--)
            push_row($urandom_range(0, 31), $urandom_range(0, 31), random_row());
         if (scene == 3) hold_req = 1;
         request_until_done(scene % 2);
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/vgm_pkg.sv
hdl/vgm_occ_mem.sv
hdl/vgm_mask_lanes.sv
hdl/vgm_run_find.sv
hdl/voxel_greedy_mesher_core.sv
dv/tb_top.sv
